FILE: rtl/euaa_pkg.sv
// euaa_pkg: widths, constants, the arctangent table and the transfer types
// shared by every module of the euler to axis-angle pipeline; no dependencies
package euaa_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;
	localparam int FULL_TURN        = 23040;
	localparam int HALF_TURN        = 11520;
	localparam int QUARTER_TURN     = 5760;
	localparam int CORDIC_GAIN_Q30  = 652032874;
	localparam int AXIS_LIMIT       = 16384;

	localparam int ANG_W  = 16;
	localparam int ROT_W  = 14;
	localparam int AXIS_W = 16;
	localparam int TRIG_W = 18;
	localparam int CV_W   = 34;
	localparam int CA_W   = 30;
	localparam int PROD_W = 2 * TRIG_W;
	localparam int NUM_W  = 36;
	localparam int U_W    = 32;
	localparam int ST_W   = 31;
	localparam int SQ_W   = 61;

	localparam int ISQ_LAT = (SQ_W + 1) / 2;
	localparam int DIV_LAT = AXIS_W + 2;

	// atan(2^-i) in degrees * 2^20
	localparam logic signed [CA_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
		30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
		30'sd3750058, 30'sd1876857, 30'sd938658, 30'sd469357,
		30'sd234682, 30'sd117342, 30'sd58671, 30'sd29335,
		30'sd14668, 30'sd7334, 30'sd3667, 30'sd1833,
		30'sd917, 30'sd458, 30'sd229, 30'sd115,
		30'sd57, 30'sd29, 30'sd14, 30'sd7
	};

	typedef struct packed {
		logic signed [ANG_W-1:0] angle_x;
		logic signed [ANG_W-1:0] angle_y;
		logic signed [ANG_W-1:0] angle_z;
	} item_t;

	typedef struct packed {
		logic [ROT_W-1:0]         rot_angle;
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [AXIS_W-1:0] axis_y;
		logic signed [AXIS_W-1:0] axis_z;
		logic                     degenerate;
	} result_t;

endpackage

FILE: rtl/euler_to_axis_angle.sv
// euler_to_axis_angle: top level, rotation matrix products, pipeline control
// depends on euaa_pkg, euaa_sincos, euaa_isqrt, euaa_axdiv, euaa_atan2
//
// Converts x, y, z euler angles (1/64 degree) of R = Rz*Ry*Rx into one
// rotation angle (1/64 degree, 0..180) and a Q2.14 axis; when the sine of
// the angle is zero the axis is zero and degenerate is set. Fully pipelined
// (two cordic pipelines, four product stages, a 31-stage square root and an
// 18-stage divider): one transfer per cycle in and out while no result is
// stalled. A stalled result holds the whole pipeline.
module euler_to_axis_angle #(
	parameter int CORDIC_STEPS = euaa_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  euaa_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output euaa_pkg::result_t result
);

	localparam int TW      = euaa_pkg::TRIG_W;
	localparam int PW      = euaa_pkg::PROD_W;
	localparam int TRI_W   = PW + TW;
	localparam int SUM_W   = PW + 2;
	localparam int NUM_W   = euaa_pkg::NUM_W;
	localparam int U_W     = euaa_pkg::U_W;
	localparam int ST_W    = euaa_pkg::ST_W;
	localparam int SQ_W    = euaa_pkg::SQ_W;
	localparam int SQP_W   = 2 * U_W;
	localparam int AW      = euaa_pkg::AXIS_W;
	localparam int SC_LAT  = CORDIC_STEPS + 2;
	localparam int MIX_LAT = 4;
	localparam int ISQ_LAT = euaa_pkg::ISQ_LAT;
	localparam int DIV_LAT = euaa_pkg::DIV_LAT;
	localparam int ATN_LAT = CORDIC_STEPS + 2;
	localparam int LAT     = SC_LAT + MIX_LAT + ISQ_LAT + DIV_LAT + ATN_LAT;

	localparam logic signed [SUM_W-1:0] ONE_Q32 = SUM_W'(1) <<< 32;
	localparam logic signed [SUM_W-1:0] U_MAX   = SUM_W'(1) <<< 30;
	localparam logic signed [SUM_W-1:0] U_MIN   = -U_MAX;
	localparam logic signed [SQP_W-1:0] ONE_Q60 = SQP_W'(1) <<< 60;
	localparam logic [euaa_pkg::ROT_W-1:0] ROT_MAX = euaa_pkg::ROT_W'(euaa_pkg::HALF_TURN);

	logic           en;
	logic [LAT-1:0] vld_s;

	logic signed [TW-1:0] sa, ca, sb, cb, sc, cc;

	logic signed [PW-1:0] cbcc_s1, cacc_s1, cacb_s1, sasb_s1, casb_s1;
	logic signed [PW-1:0] sacb_s1, sacc_s1, sasc_s1, cbsc_s1, casc_s1;
	logic signed [TW-1:0] sb_s1, sc_s1, cc_s1;

	logic signed [TRI_W-1:0] sasbsc_s2, casbsc_s2, casbcc_s2, sasbcc_s2;
	logic signed [PW-1:0] cbcc_s2, cacc_s2, cacb_s2, sacb_s2, sacc_s2;
	logic signed [PW-1:0] sasc_s2, cbsc_s2, casc_s2;
	logic signed [TW-1:0] sb_s2;

	logic signed [SUM_W-1:0] trace, u_full, u_clip, nx, ny, nz;
	logic signed [U_W-1:0]   u_s3;
	logic signed [NUM_W-1:0] nx_s3, ny_s3, nz_s3;

	logic signed [SQP_W-1:0] usq;
	logic [SQ_W-1:0]         v_s4;
	logic signed [U_W-1:0]   u_s4;
	logic signed [NUM_W-1:0] nx_s4, ny_s4, nz_s4;

	logic [ST_W-1:0]         st_root;
	logic signed [U_W-1:0]   u_a_s  [ISQ_LAT];
	logic signed [NUM_W-1:0] nx_a_s [ISQ_LAT];
	logic signed [NUM_W-1:0] ny_a_s [ISQ_LAT];
	logic signed [NUM_W-1:0] nz_a_s [ISQ_LAT];

	logic signed [AW-1:0]  ax_div, ay_div, az_div;
	logic signed [U_W-1:0] u_b_s  [DIV_LAT];
	logic [ST_W-1:0]       st_b_s [DIV_LAT];

	logic                  degen;
	logic signed [AW-1:0]  ax_c_s [ATN_LAT];
	logic signed [AW-1:0]  ay_c_s [ATN_LAT];
	logic signed [AW-1:0]  az_c_s [ATN_LAT];
	logic                  dg_c_s [ATN_LAT];
	logic [euaa_pkg::ROT_W-1:0] rot;

	// the whole pipeline advances unless a finished result is held
	assign en           = !(vld_s[LAT-1] && result_stall);
	assign item_stall   = !en;
	assign result_valid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], item_valid};
		end
	end

	euaa_sincos #(.STEPS(CORDIC_STEPS)) u_sc_x (
		.clk(clk), .en(en), .angle(item.angle_x), .sin_val(sa), .cos_val(ca)
	);
	euaa_sincos #(.STEPS(CORDIC_STEPS)) u_sc_y (
		.clk(clk), .en(en), .angle(item.angle_y), .sin_val(sb), .cos_val(cb)
	);
	euaa_sincos #(.STEPS(CORDIC_STEPS)) u_sc_z (
		.clk(clk), .en(en), .angle(item.angle_z), .sin_val(sc), .cos_val(cc)
	);

	// pair products
	always_ff @(posedge clk) begin
		if (en) begin
			cbcc_s1 <= cb * cc;
			cacc_s1 <= ca * cc;
			cacb_s1 <= ca * cb;
			sasb_s1 <= sa * sb;
			casb_s1 <= ca * sb;
			sacb_s1 <= sa * cb;
			sacc_s1 <= sa * cc;
			sasc_s1 <= sa * sc;
			cbsc_s1 <= cb * sc;
			casc_s1 <= ca * sc;
			sb_s1   <= sb;
			sc_s1   <= sc;
			cc_s1   <= cc;
		end
	end

	// triple products
	always_ff @(posedge clk) begin
		if (en) begin
			sasbsc_s2 <= sasb_s1 * sc_s1;
			casbsc_s2 <= casb_s1 * sc_s1;
			casbcc_s2 <= casb_s1 * cc_s1;
			sasbcc_s2 <= sasb_s1 * cc_s1;
			cbcc_s2   <= cbcc_s1;
			cacc_s2   <= cacc_s1;
			cacb_s2   <= cacb_s1;
			sacb_s2   <= sacb_s1;
			sacc_s2   <= sacc_s1;
			sasc_s2   <= sasc_s1;
			cbsc_s2   <= cbsc_s1;
			casc_s2   <= casc_s1;
			sb_s2     <= sb_s1;
		end
	end

	// trace, cosine term and off-diagonal differences
	always_comb begin
		trace = SUM_W'(cbcc_s2) + SUM_W'(cacc_s2) + SUM_W'(cacb_s2)
			+ SUM_W'(sasbsc_s2 >>> 16);
		u_full = (trace - ONE_Q32) >>> 3;
		if (u_full > U_MAX) begin
			u_clip = U_MAX;
		end else if (u_full < U_MIN) begin
			u_clip = U_MIN;
		end else begin
			u_clip = u_full;
		end
		nx = SUM_W'(sacb_s2) + SUM_W'(sacc_s2) - SUM_W'(casbsc_s2 >>> 16);
		ny = SUM_W'(sasc_s2) + SUM_W'(casbcc_s2 >>> 16) + (SUM_W'(sb_s2) <<< 16);
		nz = SUM_W'(cbsc_s2) + SUM_W'(casc_s2) - SUM_W'(sasbcc_s2 >>> 16);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s3  <= U_W'(u_clip);
			nx_s3 <= NUM_W'(nx);
			ny_s3 <= NUM_W'(ny);
			nz_s3 <= NUM_W'(nz);
		end
	end

	assign usq = u_s3 * u_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4  <= SQ_W'(ONE_Q60 - usq);
			u_s4  <= u_s3;
			nx_s4 <= nx_s3;
			ny_s4 <= ny_s3;
			nz_s4 <= nz_s3;
		end
	end

	euaa_isqrt u_isqrt (
		.clk(clk), .en(en), .rad(v_s4), .root(st_root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			u_a_s[0]  <= u_s4;
			nx_a_s[0] <= nx_s4;
			ny_a_s[0] <= ny_s4;
			nz_a_s[0] <= nz_s4;
			for (int k = 1; k < ISQ_LAT; k++) begin
				u_a_s[k]  <= u_a_s[k-1];
				nx_a_s[k] <= nx_a_s[k-1];
				ny_a_s[k] <= ny_a_s[k-1];
				nz_a_s[k] <= nz_a_s[k-1];
			end
		end
	end

	euaa_axdiv u_div_x (
		.clk(clk), .en(en), .numer(nx_a_s[ISQ_LAT-1]), .st(st_root), .axis(ax_div)
	);
	euaa_axdiv u_div_y (
		.clk(clk), .en(en), .numer(ny_a_s[ISQ_LAT-1]), .st(st_root), .axis(ay_div)
	);
	euaa_axdiv u_div_z (
		.clk(clk), .en(en), .numer(nz_a_s[ISQ_LAT-1]), .st(st_root), .axis(az_div)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			u_b_s[0]  <= u_a_s[ISQ_LAT-1];
			st_b_s[0] <= st_root;
			for (int k = 1; k < DIV_LAT; k++) begin
				u_b_s[k]  <= u_b_s[k-1];
				st_b_s[k] <= st_b_s[k-1];
			end
		end
	end

	assign degen = (st_b_s[DIV_LAT-1] == '0);

	euaa_atan2 #(.STEPS(CORDIC_STEPS)) u_atan2 (
		.clk(clk), .en(en), .u(u_b_s[DIV_LAT-1]), .st(st_b_s[DIV_LAT-1]), .rot(rot)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_c_s[0] <= degen ? '0 : ax_div;
			ay_c_s[0] <= degen ? '0 : ay_div;
			az_c_s[0] <= degen ? '0 : az_div;
			dg_c_s[0] <= degen;
			for (int k = 1; k < ATN_LAT; k++) begin
				ax_c_s[k] <= ax_c_s[k-1];
				ay_c_s[k] <= ay_c_s[k-1];
				az_c_s[k] <= az_c_s[k-1];
				dg_c_s[k] <= dg_c_s[k-1];
			end
		end
	end

	always_comb begin
		result.rot_angle  = rot;
		result.axis_x     = ax_c_s[ATN_LAT-1];
		result.axis_y     = ay_c_s[ATN_LAT-1];
		result.axis_z     = az_c_s[ATN_LAT-1];
		result.degenerate = dg_c_s[ATN_LAT-1];
	end

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |->
			result.axis_x == '0 && result.axis_y == '0 && result.axis_z == '0)
		else $error("degenerate result with nonzero axis");

	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.rot_angle <= ROT_MAX)
		else $error("rotation angle beyond 180 degrees");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> item_stall)
		else $error("input taken while pipeline is held");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> vld_s[0])
		else $error("accepted transfer lost at pipeline entry");

endmodule

FILE: rtl/euaa_sincos.sv
// euaa_sincos: angle reduction and pipelined rotation-mode cordic giving
// sine and cosine in Q16; depends on euaa_pkg
module euaa_sincos #(
	parameter int STEPS = euaa_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [euaa_pkg::ANG_W-1:0]   angle,
	output logic signed [euaa_pkg::TRIG_W-1:0]  sin_val,
	output logic signed [euaa_pkg::TRIG_W-1:0]  cos_val
);

	localparam int RED_W = euaa_pkg::ANG_W + 2;
	localparam int CV_W  = euaa_pkg::CV_W;
	localparam int CA_W  = euaa_pkg::CA_W;
	localparam int TW    = euaa_pkg::TRIG_W;
	localparam logic signed [RED_W-1:0] FULL     = RED_W'(euaa_pkg::FULL_TURN);
	localparam logic signed [RED_W-1:0] HALF     = RED_W'(euaa_pkg::HALF_TURN);
	localparam logic signed [RED_W-1:0] QUARTER  = RED_W'(euaa_pkg::QUARTER_TURN);
	localparam logic signed [RED_W-1:0] NQUARTER = -QUARTER;
	localparam logic signed [CV_W-1:0]  GAIN     = CV_W'(euaa_pkg::CORDIC_GAIN_Q30);
	localparam logic signed [CV_W-1:0]  RND      = CV_W'(8192);

	logic signed [RED_W-1:0] a_ext, r_mod, r_half, r_fold;
	logic                    neg_fold;
	logic signed [CV_W-1:0]  x_s [STEPS+1];
	logic signed [CV_W-1:0]  y_s [STEPS+1];
	logic signed [CA_W-1:0]  z_s [STEPS+1];
	logic                    neg_s [STEPS+1];
	logic signed [CV_W-1:0]  x_fin, y_fin, x_rnd, y_rnd;
	logic signed [TW-1:0]    sin_q, cos_q;

	always_comb begin
		a_ext = RED_W'(angle);
		if (a_ext >= FULL) begin
			r_mod = a_ext - FULL;
		end else if (a_ext < 0) begin
			r_mod = a_ext + FULL;
			if (r_mod < 0) begin
				r_mod = r_mod + FULL;
			end
		end else begin
			r_mod = a_ext;
		end
		r_half = (r_mod > HALF) ? r_mod - FULL : r_mod;
		neg_fold = 1'b0;
		r_fold = r_half;
		if (r_half > QUARTER) begin
			r_fold = r_half - HALF;
			neg_fold = 1'b1;
		end else if (r_half < NQUARTER) begin
			r_fold = r_half + HALF;
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= GAIN;
			y_s[0]   <= '0;
			z_s[0]   <= CA_W'(r_fold) <<< 14;
			neg_s[0] <= neg_fold;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - euaa_pkg::ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + euaa_pkg::ATAN_TAB[i];
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	always_comb begin
		x_fin = neg_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
		y_fin = neg_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
		x_rnd = (x_fin + RND) >>> 14;
		y_rnd = (y_fin + RND) >>> 14;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= x_rnd[TW-1:0];
			sin_q <= y_rnd[TW-1:0];
		end
	end

	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule

FILE: rtl/euaa_isqrt.sv
// euaa_isqrt: pipelined integer square root, one result bit per stage
// depends on euaa_pkg
module euaa_isqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [euaa_pkg::SQ_W-1:0]   rad,
	output logic [euaa_pkg::ST_W-1:0]   root
);

	localparam int SQ_W  = euaa_pkg::SQ_W;
	localparam int RW    = SQ_W + 1;
	localparam int STEPS = euaa_pkg::ISQ_LAT;

	logic [SQ_W-1:0] rem_s  [STEPS];
	logic [RW-1:0]   root_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (SQ_W - 1 - 2 * k);
		logic [SQ_W-1:0] rem_in;
		logic [RW-1:0]   root_in, trial;

		if (k == 0) begin : g_first
			assign rem_in  = rad;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		assign trial = root_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_in} >= trial) begin
					rem_s[k]  <= rem_in - trial[SQ_W-1:0];
					root_s[k] <= (root_in >> 1) + BIT;
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in >> 1;
				end
			end
		end
	end

	assign root = root_s[STEPS-1][euaa_pkg::ST_W-1:0];

endmodule

FILE: rtl/euaa_axdiv.sv
// euaa_axdiv: pipelined restoring divider for one axis component,
// n / (2 st) in Q2.14 rounded and saturated; depends on euaa_pkg
module euaa_axdiv (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [euaa_pkg::NUM_W-1:0]   numer,
	input  logic [euaa_pkg::ST_W-1:0]           st,
	output logic signed [euaa_pkg::AXIS_W-1:0]  axis
);

	localparam int NUM_W = euaa_pkg::NUM_W;
	localparam int ST_W  = euaa_pkg::ST_W;
	localparam int AW    = euaa_pkg::AXIS_W;
	localparam int QB    = AW - 1;
	localparam int DW    = NUM_W + 11;
	localparam logic [QB-1:0] LIMIT = QB'(euaa_pkg::AXIS_LIMIT);

	logic            neg_in;
	logic [NUM_W-1:0] mag;
	logic [DW-1:0]   num_in;

	logic [DW-1:0]   num_s0;
	logic [ST_W-1:0] st_s0;
	logic            neg_s0;

	logic [DW-1:0]   rem_s [QB+1];
	logic [QB-1:0]   q_s   [QB+1];
	logic [ST_W-1:0] st_s  [QB+1];
	logic            neg_s [QB+1];
	logic            ovf_s [QB+1];

	logic [QB-1:0]   q_sat;
	logic signed [AW-1:0] axis_q;

	always_comb begin
		neg_in = numer < 0;
		mag    = neg_in ? NUM_W'(-numer) : NUM_W'(numer);
		num_in = (DW'(mag) << 11) + DW'(st >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s0 <= num_in;
			st_s0  <= st;
			neg_s0 <= neg_in;
		end
	end

	// quotient beyond the axis range saturates
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= num_s0 >= (DW'(st_s0) << QB);
			rem_s[0] <= num_s0;
			q_s[0]   <= '0;
			st_s[0]  <= st_s0;
			neg_s[0] <= neg_s0;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_bit
		localparam int B = QB - 1 - j;
		logic [DW-1:0] dvs;
		assign dvs = DW'(st_s[j]) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[j] >= dvs) begin
					rem_s[j+1] <= rem_s[j] - dvs;
					q_s[j+1]   <= q_s[j] | (QB'(1) << B);
				end else begin
					rem_s[j+1] <= rem_s[j];
					q_s[j+1]   <= q_s[j];
				end
				st_s[j+1]  <= st_s[j];
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	assign q_sat = (ovf_s[QB] || q_s[QB] > LIMIT) ? LIMIT : q_s[QB];

	always_ff @(posedge clk) begin
		if (en) begin
			axis_q <= neg_s[QB] ? -AW'(q_sat) : AW'(q_sat);
		end
	end

	assign axis = axis_q;

endmodule

FILE: rtl/euaa_atan2.sv
// euaa_atan2: pipelined vectoring-mode cordic giving atan2(st, u) as an
// angle in 1/64 degree, clamped to 0..180 degrees; depends on euaa_pkg
module euaa_atan2 #(
	parameter int STEPS = euaa_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [euaa_pkg::U_W-1:0]    u,
	input  logic [euaa_pkg::ST_W-1:0]          st,
	output logic [euaa_pkg::ROT_W-1:0]         rot
);

	localparam int CV_W = euaa_pkg::CV_W;
	localparam int CA_W = euaa_pkg::CA_W;
	localparam logic signed [CA_W-1:0] Z_NEG = euaa_pkg::ATAN_TAB[0] <<< 1;
	localparam logic signed [CA_W-1:0] RND   = CA_W'(8192);
	localparam logic signed [CA_W-1:0] HALF  = CA_W'(euaa_pkg::HALF_TURN);

	logic signed [CV_W-1:0] x_s [STEPS+1];
	logic signed [CV_W-1:0] y_s [STEPS+1];
	logic signed [CA_W-1:0] z_s [STEPS+1];
	logic signed [CA_W-1:0] z_clip, z_rnd;
	logic [euaa_pkg::ROT_W-1:0] rot_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (u < 0) begin
				x_s[0] <= CV_W'(st);
				y_s[0] <= -CV_W'(u);
				z_s[0] <= Z_NEG;
			end else begin
				x_s[0] <= CV_W'(u);
				y_s[0] <= CV_W'(st);
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + euaa_pkg::ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - euaa_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	always_comb begin
		z_clip = (z_s[STEPS] < 0) ? '0 : z_s[STEPS];
		z_rnd  = (z_clip + RND) >>> 14;
		if (z_rnd > HALF) begin
			z_rnd = HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q <= z_rnd[euaa_pkg::ROT_W-1:0];
		end
	end

	assign rot = rot_q;

endmodule

FILE: sim/euaa_checker.sv
// euaa_checker: watches both transfer channels of euler_to_axis_angle, predicts
// each result in fixed point and compares it field by field; depends on euaa_pkg
module euaa_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  euaa_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  euaa_pkg::result_t result,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = (euaa_pkg::CORDIC_STEPS_DEF > euaa_pkg::ATAN_ENTRIES)
		? euaa_pkg::ATAN_ENTRIES : euaa_pkg::CORDIC_STEPS_DEF;
	localparam int ANG_W = euaa_pkg::ANG_W;
	localparam int AW    = euaa_pkg::AXIS_W;
	localparam int ROT_W = euaa_pkg::ROT_W;
	localparam longint FULL    = euaa_pkg::FULL_TURN;
	localparam longint HALF    = euaa_pkg::HALF_TURN;
	localparam longint QUARTER = euaa_pkg::QUARTER_TURN;

	euaa_pkg::result_t expected_q[$];

	function automatic longint atan_at(int i);
		return longint'(euaa_pkg::ATAN_TAB[i]);
	endfunction

	function automatic void trig_q16(input logic signed [ANG_W-1:0] a,
			output longint s, output longint c);
		longint r, x, y, z, dx, dy;
		bit flip;
		r = longint'(a) % FULL;
		x = euaa_pkg::CORDIC_GAIN_Q30;
		y = 0;
		flip = 0;
		if (r < 0) r += FULL;
		if (r > HALF) r -= FULL;
		if (r > QUARTER) begin
			r -= HALF;
			flip = 1;
		end else if (r < -QUARTER) begin
			r += HALF;
			flip = 1;
		end
		z = r * 16384;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_at(i);
			end else begin
				x += dx; y -= dy; z += atan_at(i);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = (x + 8192) >>> 14;
		s = (y + 8192) >>> 14;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic logic signed [AW-1:0] axis_comp(longint n, longint st);
		longint unsigned m, q;
		m = (n < 0) ? longint'(-n) : n;
		q = ((m << 11) + (st >> 1)) / st;
		if (q > euaa_pkg::AXIS_LIMIT) q = euaa_pkg::AXIS_LIMIT;
		return (n < 0) ? AW'(-longint'(q)) : AW'(longint'(q));
	endfunction

	function automatic euaa_pkg::result_t predict_axis_angle(euaa_pkg::item_t it);
		longint sa, ca, sb, cb, sc, cc, tr, u, st, nx, ny, nz, x, y, z, dx, dy, ang;
		euaa_pkg::result_t r;
		trig_q16(it.angle_x, sa, ca);
		trig_q16(it.angle_y, sb, cb);
		trig_q16(it.angle_z, sc, cc);
		tr = cb * cc + ca * cc + ca * cb + ((sa * sb * sc) >>> 16);
		u = (tr - (64'sd1 << 32)) >>> 3;
		if (u > (64'sd1 << 30)) u = 64'sd1 << 30;
		if (u < -(64'sd1 << 30)) u = -(64'sd1 << 30);
		st = int_sqrt((64'd1 << 60) - longint'(u * u));
		nx = sa * cb + sa * cc - ((ca * sb * sc) >>> 16);
		ny = sa * sc + ((ca * sb * cc) >>> 16) + sb * 65536;
		nz = cb * sc + ca * sc - ((sa * sb * cc) >>> 16);
		if (u < 0) begin
			x = st; y = -u; z = atan_at(0) * 2;
		end else begin
			x = u; y = st; z = 0;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_at(i);
			end else begin
				x -= dx; y += dy; z -= atan_at(i);
			end
		end
		if (z < 0) z = 0;
		ang = (z + 8192) >>> 14;
		if (ang > HALF) ang = HALF;
		r = '0;
		r.rot_angle = ang[ROT_W-1:0];
		r.degenerate = (st == 0);
		if (st != 0) begin
			r.axis_x = axis_comp(nx, st);
			r.axis_y = axis_comp(ny, st);
			r.axis_z = axis_comp(nz, st);
		end
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		euaa_pkg::result_t e;
		if (!arst_n) begin
			errors = 0;
			expected_q.delete();
		end else begin
			if (item_valid && !item_stall)
				expected_q.push_back(predict_axis_angle(item));
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					e = expected_q.pop_front();
					if (result.rot_angle != e.rot_angle)
						report("rot_angle", result.rot_angle, e.rot_angle);
					if (result.axis_x != e.axis_x) report("axis_x", result.axis_x, e.axis_x);
					if (result.axis_y != e.axis_y) report("axis_y", result.axis_y, e.axis_y);
					if (result.axis_z != e.axis_z) report("axis_z", result.axis_z, e.axis_z);
					if (result.degenerate != e.degenerate)
						report("degenerate", result.degenerate, e.degenerate);
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

FILE: sim/euler_to_axis_angle_tb.sv
// euler_to_axis_angle_tb: drives directed and random euler angles through
// euler_to_axis_angle with bursty input and stalling output; depends on euaa_pkg, euaa_checker
module euler_to_axis_angle_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 2 * euaa_pkg::CORDIC_STEPS_DEF + 57;
	localparam int N_RANDOM = 700;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int ANG_W   = euaa_pkg::ANG_W;
	localparam int FULL    = euaa_pkg::FULL_TURN;
	localparam int HALF    = euaa_pkg::HALF_TURN;
	localparam int QUARTER = euaa_pkg::QUARTER_TURN;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              item_valid = 0;
	logic              item_stall;
	euaa_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_stall = 0;
	euaa_pkg::result_t result;
	int                errors;
	int                pending;
	longint            cycles = 0;
	bit                hold_off = 0;
	bit                stim_done = 0;

	always #5 clk = ~clk;

	euler_to_axis_angle u_dut (.*);

	euaa_checker u_checker (.*);

	function automatic logic signed [ANG_W-1:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return ANG_W'(-FULL);
			1: return ANG_W'(FULL);
			2: return ANG_W'(int'($urandom_range(0, 8)) * 2880 - FULL);
			3: return ANG_W'($urandom_range(0, 65535));
			default: return ANG_W'(int'($urandom_range(0, 2 * FULL)) - FULL);
		endcase
	endfunction

	task automatic send_orientation(int ax, int ay, int az);
		item.angle_x <= ANG_W'(ax);
		item.angle_y <= ANG_W'(ay);
		item.angle_z <= ANG_W'(az);
		item_valid <= 1;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		item_valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	// receiver stall pattern, with one long hold-off
	initial begin
		int mode;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) result_stall <= 1;
			else begin
				mode = int'((cycles / 500) % 3);
				case (mode)
					0: result_stall <= 0;
					1: result_stall <= ($urandom_range(0, 3) == 0);
					default: result_stall <= ($urandom_range(0, 1) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int dir[$];
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		dir = '{0, 0, 0,   FULL, -FULL, FULL,   HALF, 0, 0,
			0, HALF, 0,   0, 0, HALF,   -HALF, -HALF, -HALF,
			QUARTER, QUARTER, QUARTER,   -QUARTER, 0, QUARTER,
			1, -1, 1,   32767, -32768, 32767,   -32768, 32767, -32768,
			FULL + 64, -FULL - 64, 2880,   HALF, HALF, 0,
			0, HALF, HALF,   HALF - 1, 1, -1,   1000, -7777, 12345};
		for (int i = 0; i < dir.size(); i += 3) send_orientation(dir[i], dir[i+1], dir[i+2]);
		// drain completely before random traffic
		idle_gap(1);
		while (pending != 0) @(negedge clk);
		// long receiver hold-off while input keeps coming
		fork
			begin
				hold_off = 1;
				repeat (3 * LATENCY) @(negedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 2 * LATENCY; i++)
				send_orientation(rand_angle(), rand_angle(), rand_angle());
		join
		for (int i = 0; i < N_RANDOM; ) begin
			int burst;
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++, i++)
				send_orientation(rand_angle(), rand_angle(), rand_angle());
			if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
		end
		idle_gap(1);
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
